### rtl/marker_framed_sum_product_responder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the marker framed sum/product responder
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MARKER_FRAMED_SUM_PRODUCT_RESPONDER_ASSERT_SVH
`define MARKER_FRAMED_SUM_PRODUCT_RESPONDER_ASSERT_SVH

// Same-cycle implication.
`define MFSPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MFSPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mfspr_pkg.sv
// ----------------------------------------------------------------------------
// mfspr_pkg
// Shared constants, result codes and the response record of the responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfspr_pkg;

	localparam logic [7:0] START_HI = 8'hFF;
	localparam logic [7:0] START_LO = 8'hFE;
	localparam logic [7:0] END_HI   = 8'hFD;
	localparam logic [7:0] END_LO   = 8'hFC;

	localparam int FRAME_LEN  = 18;
	localparam int DATA_LEN   = 16;
	localparam int RESP_BEATS = 8;
	localparam int CNT_W      = $clog2(RESP_BEATS + 1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_BAD_END = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// What the current beat would produce if it were processed now.
	typedef struct packed {
		logic        hit;
		logic [1:0]  kind;
		logic [63:0] data;
	} resp_t;

endpackage

### rtl/marker_framed_sum_product_responder.sv
// A result beat is offered from the result register once its input beat has passed the
// input register and the framer. Throughput: one input beat per cycle while item_stall is
// low; a good frame answers with 8 result beats at one per cycle while result_stall is low.
// Input stalls only while an item that yields results waits for the result
// register to drain. Reset clears all control state and sets timeout_ticks to 1000.
// ----------------------------------------------------------------------------
// marker_framed_sum_product_responder
// Top level: input register, framer, result burst register and config register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marker_framed_sum_product_responder
	import mfspr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic             valid_s1;
	logic             action_s1;
	logic [7:0]       byte_s1;
	logic [15:0]      timeout_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       kind_q;
	logic [63:0]      data_q;

	resp_t resp;
	logic  in_accept;
	logic  out_accept;
	logic  buf_free;
	logic  advance;
	logic  step;

	assign cfg_ready = 1'b1;

	assign out_accept = result_valid && !result_stall;
	assign buf_free   = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_accept);
	assign advance    = !resp.hit || buf_free;
	assign step       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign in_accept  = item_valid && !item_stall;

	mfspr_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.action        (action_s1),
		.rx_byte       (byte_s1),
		.timeout_ticks (timeout_q),
		.resp          (resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
			cnt_q     <= '0;
			kind_q    <= KIND_DATA;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (step && resp.hit) begin
				kind_q <= resp.kind;
				cnt_q  <= (resp.kind == KIND_DATA) ? CNT_W'(RESP_BEATS) : CNT_W'(1);
			end else if (out_accept) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1 <= action;
			byte_s1   <= rx_byte;
		end
		if (step && resp.hit) begin
			data_q <= resp.data;
		end else if (out_accept) begin
			data_q <= {8'd0, data_q[63:8]};
		end
	end

	assign result_valid = (cnt_q != '0);
	assign kind         = kind_q;
	assign tx_byte      = data_q[7:0];
	assign last         = (cnt_q == CNT_W'(1));

`include "marker_framed_sum_product_responder_assert.svh"

	`MFSPR_ASSERT_NOW(a_stall_needs_busy, item_stall, result_valid, "input stalled with empty result register")
	`MFSPR_ASSERT_NOW(a_status_single, result_valid && (kind != KIND_DATA), last && (tx_byte == 8'd0), "status beat is not a lone zero beat")
	`MFSPR_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(RESP_BEATS), "result beat count out of range")
	`MFSPR_ASSERT_NEXT(a_load_valid, step && resp.hit, result_valid, "result load did not raise result_valid")

endmodule

### rtl/mfspr_frame.sv
// ----------------------------------------------------------------------------
// mfspr_frame
// Start marker hunt, payload capture, timeout and the sum/product arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfspr_frame
	import mfspr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] timeout_ticks,
	output resp_t       resp
);

	typedef enum logic [1:0] {
		HUNT    = 2'd0,
		COLLECT = 2'd1
	} phase_t;

	localparam int SR_DEPTH = FRAME_LEN - 1;

	phase_t      phase_q;
	logic [7:0]  pair_first_q;
	logic        pair_half_q;
	logic [4:0]  byte_count_q;
	logic [15:0] tick_count_q;
	logic [7:0]  payload_q [SR_DEPTH];

	logic        collecting;
	logic [15:0] tick_next;
	logic        hit_timeout;
	logic        frame_done;
	logic        end_ok;
	logic [31:0] w0, w1, w2, w3;
	logic [31:0] sum;
	logic [31:0] prod;

	assign collecting = (phase_q == COLLECT);
	assign tick_next  = (tick_count_q != 16'hFFFF) ? tick_count_q + 16'd1 : tick_count_q;

	assign hit_timeout = collecting && action && (tick_next >= timeout_ticks);
	assign frame_done  = collecting && !action && (byte_count_q == 5'(FRAME_LEN - 1));
	assign end_ok      = (payload_q[DATA_LEN] == END_HI) && (rx_byte == END_LO);

	assign w0 = {payload_q[3],  payload_q[2],  payload_q[1],  payload_q[0]};
	assign w1 = {payload_q[7],  payload_q[6],  payload_q[5],  payload_q[4]};
	assign w2 = {payload_q[11], payload_q[10], payload_q[9],  payload_q[8]};
	assign w3 = {payload_q[15], payload_q[14], payload_q[13], payload_q[12]};

	// Low 32 bits of the product are the same for signed and unsigned operands.
	assign sum  = w0 + w1;
	assign prod = w2 * w3;

	always_comb begin
		resp.hit  = hit_timeout || frame_done;
		resp.kind = hit_timeout ? KIND_TIMEOUT : (end_ok ? KIND_DATA : KIND_BAD_END);
		resp.data = (frame_done && end_ok) ? {prod, sum} : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= HUNT;
			pair_first_q <= 8'd0;
			pair_half_q  <= 1'b0;
			byte_count_q <= 5'd0;
			tick_count_q <= 16'd0;
		end else if (step) begin
			case (phase_q)
				COLLECT: begin
					if (hit_timeout || frame_done) begin
						phase_q      <= HUNT;
						pair_first_q <= 8'd0;
						pair_half_q  <= 1'b0;
						byte_count_q <= 5'd0;
						tick_count_q <= 16'd0;
					end else if (action) begin
						tick_count_q <= tick_next;
					end else begin
						byte_count_q <= byte_count_q + 5'd1;
					end
				end
				default: begin
					// Ticks are ignored while hunting.
					if (!action) begin
						if (!pair_half_q) begin
							pair_first_q <= rx_byte;
							pair_half_q  <= 1'b1;
						end else begin
							pair_half_q <= 1'b0;
							if (pair_first_q == START_HI && rx_byte == START_LO) begin
								phase_q      <= COLLECT;
								byte_count_q <= 5'd0;
								tick_count_q <= 16'd0;
							end
						end
					end
				end
			endcase
		end
	end

	// Bytes shift in from the top, so when the last frame byte arrives entry i holds byte i.
	always_ff @(posedge clk) begin
		if (step && collecting && !action) begin
			for (int i = 0; i < SR_DEPTH - 1; i++) begin
				payload_q[i] <= payload_q[i + 1];
			end
			payload_q[SR_DEPTH - 1] <= rx_byte;
		end
	end

endmodule

### sim/marker_framed_sum_product_responder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_framed_sum_product_responder_tb
// Drives byte and tick beats into the responder and checks every result beat
// against a frame predictor kept in the bench, under random idling on both sides.
// ----------------------------------------------------------------------------

module marker_framed_sum_product_responder_tb;
	import mfspr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       tail;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        action;
	logic [7:0]  rx_byte;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Predictor state.
	logic [15:0] timeout_reg = TIMEOUT_RESET;
	bit          collecting = 1'b0;
	bit          half_seen = 1'b0;
	logic [7:0]  first_byte = 8'h00;
	int          nbytes = 0;
	logic [15:0] ticks = 16'h0000;
	logic [7:0]  frame_bytes [FRAME_LEN];

	reply_t replies_due [$];
	int     mismatches = 0;
	int     beats_counted = 0;
	int     quiet = 0;
	int     sink_wait = 0;
	bit     send_idle = 1'b0;
	bit     sink_idle = 1'b0;
	bit     hold_results = 1'b0;

	marker_framed_sum_product_responder uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.tx_byte(tx_byte),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int pace(input bit enabled);
		if (!enabled || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic void queue_reply(input logic [1:0] k, input logic [7:0] d,
			input logic t);
		reply_t r;
		r.kind = k;
		r.data = d;
		r.tail = t;
		replies_due.push_back(r);
	endfunction

	// Advances the frame predictor by one accepted beat.
	task automatic predict_beat(input logic act, input logic [7:0] b);
		logic [31:0] w [4];
		logic [31:0] total;
		logic [31:0] prod;
		if (!collecting) begin
			if (act)
				return;
			if (!half_seen) begin
				first_byte = b;
				half_seen = 1'b1;
			end else begin
				half_seen = 1'b0;
				if (first_byte == START_HI && b == START_LO) begin
					collecting = 1'b1;
					nbytes = 0;
					ticks = 16'h0000;
				end
			end
			return;
		end
		if (act) begin
			if (ticks != 16'hFFFF)
				ticks = ticks + 16'd1;
			if (ticks >= timeout_reg) begin
				queue_reply(KIND_TIMEOUT, 8'h00, 1'b1);
				collecting = 1'b0;
				half_seen = 1'b0;
			end
			return;
		end
		frame_bytes[nbytes] = b;
		nbytes++;
		if (nbytes < FRAME_LEN)
			return;
		if (frame_bytes[DATA_LEN] == END_HI && frame_bytes[DATA_LEN + 1] == END_LO) begin
			for (int k = 0; k < 4; k++)
				w[k] = {frame_bytes[4 * k + 3], frame_bytes[4 * k + 2],
					frame_bytes[4 * k + 1], frame_bytes[4 * k]};
			total = w[0] + w[1];
			prod = w[2] * w[3];
			for (int k = 0; k < 4; k++)
				queue_reply(KIND_DATA, total[8 * k +: 8], 1'b0);
			for (int k = 0; k < 4; k++)
				queue_reply(KIND_DATA, prod[8 * k +: 8], k == 3);
		end else begin
			queue_reply(KIND_BAD_END, 8'h00, 1'b1);
		end
		collecting = 1'b0;
		half_seen = 1'b0;
	endtask

	// Offers one beat and returns right after the edge that accepts it. Valid is
	// left high so that a following beat with no gap keeps it high.
	task automatic send_beat(input logic act, input logic [7:0] b);
		int gap;
		gap = pace(send_idle);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		rx_byte <= act ? 8'($urandom) : b;
		do @(posedge clk); while (item_stall);
		if (!act || collecting)
			beats_counted++;
		predict_beat(act, b);
	endtask

	task automatic send_start();
		send_beat(1'b0, START_HI);
		send_beat(1'b0, START_LO);
	endtask

	task automatic send_words(input logic [127:0] words, input logic [7:0] end_hi,
			input logic [7:0] end_lo);
		send_start();
		for (int i = 0; i < DATA_LEN; i++)
			send_beat(1'b0, words[8 * i +: 8]);
		send_beat(1'b0, end_hi);
		send_beat(1'b0, end_lo);
	endtask

	// Waits until every expected result is out and the pipeline has gone quiet.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		timeout_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A framed request with random content, optional ticks between the beats and
	// an end marker that is either correct or corrupted.
	task automatic send_frame(input bit good_end, input int tick_odds);
		logic [7:0] body [FRAME_LEN];
		int style;
		style = $urandom_range(0, 6);
		for (int i = 0; i < DATA_LEN; i++) begin
			case (style)
				0: body[i] = 8'hFF;
				1: body[i] = 8'h00;
				2: body[i] = (i % 4 == 3) ? 8'h80 : 8'h00;
				3: body[i] = (i % 4 == 3) ? 8'h7F : 8'hFF;
				default: body[i] = 8'($urandom);
			endcase
		end
		if (good_end) begin
			body[DATA_LEN] = END_HI;
			body[DATA_LEN + 1] = END_LO;
		end else begin
			body[DATA_LEN] = $urandom_range(0, 1) ? END_HI : 8'($urandom);
			body[DATA_LEN + 1] = (body[DATA_LEN] == END_HI) ?
				END_LO ^ (8'h01 << $urandom_range(0, 7)) : 8'($urandom);
		end
		send_start();
		for (int i = 0; i < FRAME_LEN; i++) begin
			if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
				send_beat(1'b1, 8'h00);
			send_beat(1'b0, body[i]);
		end
	endtask

	task automatic test_hunting();
		send_beat(1'b1, 8'h00);
		send_beat(1'b0, 8'h00);
		send_beat(1'b0, START_HI);
		send_beat(1'b0, START_LO);
		send_beat(1'b0, 8'h00);
		send_beat(1'b1, 8'hFF);
		send_beat(1'b0, 8'h7F);
		send_beat(1'b0, 8'hA5);
	endtask

	task automatic test_good_frame();
		// Signed overflow on the sum and the most negative word times minus one.
		send_words({32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF},
			END_HI, END_LO);
		settle();
	endtask

	task automatic test_bad_end();
		send_words({32'h0123_4567, 32'h89AB_CDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFE},
			END_HI, END_HI);
		settle();
	endtask

	task automatic test_timeouts();
		write_timeout(16'd2);
		send_start();
		send_beat(1'b0, 8'h11);
		send_beat(1'b1, 8'h00);
		send_beat(1'b0, 8'h22);
		send_beat(1'b1, 8'h00);
		settle();
		// A limit of zero expires on the very first tick.
		write_timeout(16'd0);
		send_start();
		send_beat(1'b1, 8'h00);
		settle();
	endtask

	task automatic test_long_timeout();
		send_idle = 1'b0;
		write_timeout(16'd24);
		send_start();
		for (int i = 0; i < 24; i++)
			send_beat(1'b1, 8'h00);
		settle();
	endtask

	task automatic test_backpressure();
		send_idle = 1'b0;
		sink_idle = 1'b0;
		write_timeout(16'd1000);
		fork
			begin
				@(posedge clk);
				hold_results = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
		join_none
		for (int i = 0; i < 3; i++)
			send_frame(1'b1, 0);
		settle();
	endtask

	task automatic test_random_traffic();
		logic [15:0] limits [6];
		int goal;
		int pick;
		int tick_odds;
		limits = '{16'd1000, 16'd7, 16'd0, 16'hFFFF, 16'd3, 16'd1};
		for (int p = 0; p < 6; p++) begin
			write_timeout(limits[p]);
			send_idle = (p != 2);
			sink_idle = (p != 2);
			goal = beats_counted + 12;
			while (beats_counted < goal) begin
				pick = $urandom_range(0, 9);
				tick_odds = $urandom_range(0, 1) ? 0 : 6;
				if (pick < 2) begin
					// Noise: loose bytes and ticks, which may leave the pair phase odd.
					repeat ($urandom_range(1, 4))
						send_beat($urandom_range(0, 3) == 0, 8'($urandom));
				end else begin
					send_frame(pick != 2, tick_odds);
				end
			end
			settle();
		end
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		$display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (replies_due.size() == 0) begin
				report_mismatch("unexpected beat kind", -1, kind);
			end else begin
				want = replies_due.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", want.kind, kind);
				if (tx_byte !== want.data)
					report_mismatch("tx_byte", want.data, tx_byte);
				if (last !== want.tail)
					report_mismatch("last", want.tail, last);
			end
			sink_wait = pace(sink_idle);
		end
	end

	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results || sink_wait > 0) begin
				result_stall <= 1'b1;
				if (sink_wait > 0)
					sink_wait--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("marker_framed_sum_product_responder regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		action = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_data = 16'h0000;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_hunting();
		test_good_frame();
		test_bad_end();
		test_timeouts();
		test_long_timeout();
		test_backpressure();
		test_random_traffic();

		settle();
		if (mismatches == 0)
			$display("marker_framed_sum_product_responder regression: pass");
		else
			$display("marker_framed_sum_product_responder regression: fail");
		$finish;
	end

endmodule
